// File: rtl/pps_pkg.sv
package pps_pkg;

  localparam int unsigned SLOTS_DEF = 16;

  typedef enum logic {
    OP_ARRIVE = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_ACCEPT = 2'd0,
    ST_FULL   = 2'd1,
    ST_RAN    = 2'd2,
    ST_IDLE   = 2'd3
  } status_e;

  // classified command handed from the front to the back
  typedef struct packed {
    op_e         op;
    logic [7:0]  id;
    logic [15:0] burst;
    logic [7:0]  prio;
  } cmd_t;

  // one task slot as kept in the slot RAM
  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] arrival;
    logic [15:0] burst;
    logic [15:0] remaining;
    logic [7:0]  prio;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

  // one result beat
  typedef struct packed {
    status_e     status;
    logic [7:0]  ran_id;
    logic        finished;
    logic [31:0] completion_time;
    logic [31:0] turnaround;
    logic [31:0] waiting;
  } out_t;

endpackage

// File: rtl/preemptive_priority_scheduler_top.sv
// Preemptive priority scheduler over SLOTS task slots. An arrive beat
// (opcode 0) places the task in the lowest free slot, stamped with the
// current time, and answers status 0, or status 1 when every slot is taken.
// A tick beat (opcode 1) advances time by one and serves the waiting task
// with the smallest priority number (ties: earlier arrival, then lower
// slot), answering status 2 with its id; when its burst is used up the beat
// also carries finished, completion time, turnaround and waiting time, and
// the slot is freed. A tick with no task answers status 3. Every input beat
// gives exactly one result beat. The input side pushes beats into a two-deep
// command queue, so it keeps taking beats while a result waits on the
// output register, until the queue is full. The executor works one command
// at a time and walks the slot RAM one entry per cycle through its single
// read port: an arrival walks up to the first free slot (the whole table
// when full); a tick walks every slot, then its drain, update and result states.
// Slot storage needs no clearing after reset; per-slot valid flags are
// cleared by reset directly.
module preemptive_priority_scheduler_top #(
  parameter int unsigned SLOTS = pps_pkg::SLOTS_DEF,
  localparam int unsigned IDX_W = $clog2(SLOTS)
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [7:0]  task_id_i,
  input  logic [15:0] burst_length_i,
  input  logic [7:0]  priority_level_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [7:0]  ran_id_o,
  output logic        finished_o,
  output logic [31:0] completion_time_o,
  output logic [31:0] turnaround_o,
  output logic [31:0] waiting_o
);

  pps_pkg::cmd_t               cmd;
  logic                        cmd_valid;
  logic                        cmd_pop;
  logic                        ram_we;
  logic [IDX_W-1:0]            ram_waddr;
  logic [pps_pkg::SLOT_W-1:0]  ram_wdata;
  logic [IDX_W-1:0]            ram_raddr;
  logic [pps_pkg::SLOT_W-1:0]  ram_rdata;
  pps_pkg::out_t               out;

  // classify input beats and queue them
  pps_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .task_id_i        (task_id_i),
    .burst_length_i   (burst_length_i),
    .priority_level_i (priority_level_i),
    .cmd_valid_o      (cmd_valid),
    .cmd_o            (cmd),
    .cmd_pop_i        (cmd_pop)
  );

  // execute commands against the slot table
  pps_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out)
  );

  // slot records: id, arrival stamp, burst, remaining, priority
  pps_ram #(
    .WIDTH (pps_pkg::SLOT_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign status_o          = out.status;
  assign ran_id_o          = out.ran_id;
  assign finished_o        = out.finished;
  assign completion_time_o = out.completion_time;
  assign turnaround_o      = out.turnaround;
  assign waiting_o         = out.waiting;

endmodule

// File: rtl/pps_ram.sv
module pps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/pps_front.sv
module pps_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                opcode_i,
  input  logic [7:0]          task_id_i,
  input  logic [15:0]         burst_length_i,
  input  logic [7:0]          priority_level_i,
  output logic                cmd_valid_o,
  output pps_pkg::cmd_t       cmd_o,
  input  logic                cmd_pop_i
);

  pps_pkg::cmd_t fifo_q [2];
  pps_pkg::cmd_t cmd_in;
  logic          wptr_q, wptr_d;
  logic          rptr_q, rptr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          push, pop;

  // a zero burst runs as one tick
  always_comb begin
    cmd_in.op    = pps_pkg::op_e'(opcode_i);
    cmd_in.id    = task_id_i;
    cmd_in.burst = (burst_length_i == 16'd0) ? 16'd1 : burst_length_i;
    cmd_in.prio  = priority_level_i;
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wptr_d = push ? ~wptr_q : wptr_q;
    rptr_d = pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= cmd_in;
    end
  end

endmodule

// File: rtl/pps_back.sv
module pps_back #(
  parameter int unsigned SLOTS = pps_pkg::SLOTS_DEF,
  localparam int unsigned IDX_W = $clog2(SLOTS)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  input  pps_pkg::cmd_t               cmd_i,
  output logic                        cmd_pop_o,
  output logic                        ram_we_o,
  output logic [IDX_W-1:0]            ram_waddr_o,
  output logic [pps_pkg::SLOT_W-1:0]  ram_wdata_o,
  output logic [IDX_W-1:0]            ram_raddr_o,
  input  logic [pps_pkg::SLOT_W-1:0]  ram_rdata_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output pps_pkg::out_t               out_o
);

  localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DRAIN  = 5'b00100,
    S_UPDATE = 5'b01000,
    S_RESULT = 5'b10000
  } state_e;

  typedef struct packed {
    pps_pkg::status_e status;
    logic [7:0]       id;
    logic             fin;
    logic [31:0]      ct;
    logic [31:0]      tat;
    logic [15:0]      burst;
  } res_t;

  state_e             state_q, state_d;
  pps_pkg::cmd_t      cmd_q, cmd_d;
  logic [SLOTS-1:0]   valid_q, valid_d;
  logic [31:0]        now_q, now_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               eval_q, eval_d;
  logic [IDX_W-1:0]   eval_idx_q, eval_idx_d;
  logic               found_q, found_d;
  pps_pkg::slot_t     best_q, best_d;
  logic [IDX_W-1:0]   best_idx_q, best_idx_d;
  res_t               res_q, res_d;
  logic               out_valid_q, out_valid_d;
  pps_pkg::out_t      out_q, out_d;
  pps_pkg::slot_t     rd_slot, wr_slot;
  logic [15:0]        rem_next;

  assign rd_slot  = pps_pkg::slot_t'(ram_rdata_i);
  assign rem_next = best_q.remaining - 16'd1;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    valid_d     = valid_q;
    now_d       = now_q;
    idx_d       = idx_q;
    eval_d      = eval_q;
    eval_idx_d  = eval_idx_q;
    found_d     = found_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    cmd_pop_o   = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = idx_q;
    ram_raddr_o = idx_q;
    wr_slot     = best_q;

    // compare the slot read last cycle against the best so far
    if ((state_q == S_SCAN || state_q == S_DRAIN) && eval_q && valid_q[eval_idx_q]) begin
      if (!found_q || (rd_slot.prio < best_q.prio) ||
          ((rd_slot.prio == best_q.prio) && (rd_slot.arrival < best_q.arrival))) begin
        best_d     = rd_slot;
        best_idx_d = eval_idx_q;
        found_d    = 1'b1;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          idx_d     = '0;
          eval_d    = 1'b0;
          found_d   = 1'b0;
          if (cmd_i.op == pps_pkg::OP_TICK) begin
            now_d = now_q + 32'd1;
          end
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cmd_q.op == pps_pkg::OP_ARRIVE) begin
          res_d = '{status: pps_pkg::ST_ACCEPT, id: 8'd0, fin: 1'b0,
                    ct: 32'd0, tat: 32'd0, burst: 16'd0};
          if (!valid_q[idx_q]) begin
            wr_slot.id        = cmd_q.id;
            wr_slot.arrival   = now_q;
            wr_slot.burst     = cmd_q.burst;
            wr_slot.remaining = cmd_q.burst;
            wr_slot.prio      = cmd_q.prio;
            ram_we_o          = 1'b1;
            valid_d[idx_q]    = 1'b1;
            state_d           = S_RESULT;
          end else if (idx_q == LAST) begin
            res_d.status = pps_pkg::ST_FULL;
            state_d      = S_RESULT;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end else begin
          eval_d     = 1'b1;
          eval_idx_d = idx_q;
          if (idx_q == LAST) begin
            state_d = S_DRAIN;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
      end
      S_DRAIN: begin
        eval_d  = 1'b0;
        state_d = S_UPDATE;
      end
      S_UPDATE: begin
        res_d = '{status: pps_pkg::ST_IDLE, id: 8'd0, fin: 1'b0,
                  ct: 32'd0, tat: 32'd0, burst: 16'd0};
        if (found_q) begin
          res_d.status = pps_pkg::ST_RAN;
          res_d.id     = best_q.id;
          if (rem_next == 16'd0) begin
            valid_d[best_idx_q] = 1'b0;
            res_d.fin           = 1'b1;
            res_d.ct            = now_q;
            res_d.tat           = now_q - best_q.arrival;
            res_d.burst         = best_q.burst;
          end else begin
            wr_slot.remaining = rem_next;
            ram_waddr_o       = best_idx_q;
            ram_we_o          = 1'b1;
          end
        end
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d           = 1'b1;
          out_d.status          = res_q.status;
          out_d.ran_id          = res_q.id;
          out_d.finished        = res_q.fin;
          out_d.completion_time = res_q.ct;
          out_d.turnaround      = res_q.tat;
          out_d.waiting         = res_q.fin ? (res_q.tat - {16'd0, res_q.burst}) : 32'd0;
          state_d               = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign ram_wdata_o = wr_slot;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      now_q       <= 32'd0;
      eval_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      now_q       <= now_d;
      eval_q      <= eval_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    idx_q      <= idx_d;
    eval_idx_q <= eval_idx_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

endmodule

// File: rtl/pps_checker.sv
module pps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [7:0]  ran_id_o,
  input logic        finished_o,
  input logic [31:0] completion_time_o,
  input logic [31:0] turnaround_o,
  input logic [31:0] waiting_o
);

  logic [31:0] burst_seen;

  assign burst_seen = turnaround_o - waiting_o;

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o &&
      $stable({status_o, ran_id_o, finished_o, completion_time_o,
               turnaround_o, waiting_o}))
    else $error("result beat changed while stalled");

  // only a served task carries an id or a finish flag
  a_no_task: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != pps_pkg::ST_RAN) |-> (ran_id_o == 8'd0) && !finished_o)
    else $error("id or finish flag without a served task");

  // timing fields stay zero unless the task finished
  a_zero_times: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !finished_o |->
      (completion_time_o == 32'd0) && (turnaround_o == 32'd0) && (waiting_o == 32'd0))
    else $error("timing fields set on an unfinished beat");

  // turnaround minus waiting gives back a legal burst
  a_burst_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && finished_o |-> (burst_seen != 32'd0) && (burst_seen[31:16] == 16'd0))
    else $error("turnaround and waiting disagree with any burst");

endmodule

bind preemptive_priority_scheduler_top pps_checker u_pps_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .status_o          (status_o),
  .ran_id_o          (ran_id_o),
  .finished_o        (finished_o),
  .completion_time_o (completion_time_o),
  .turnaround_o      (turnaround_o),
  .waiting_o         (waiting_o)
);

// File: test/tb_preemptive_priority_scheduler_top.sv
module tb_preemptive_priority_scheduler_top;
  import pps_pkg::*;

  localparam int unsigned SLOTS = SLOTS_DEF;
  // Stop idling on both sides for the last beats of the run.
  localparam int unsigned CALM_BEATS = 200;
  localparam int unsigned RANDOM_BEATS = 1800;
  // A tick walks the whole slot RAM before its result reaches the output register.
  localparam int unsigned TAIL_CYCLES = 3 * (SLOTS + 4);
  localparam int unsigned HOLD_OFF_CYCLES = 500;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        opcode_i = 1'b0;
  logic [7:0]  task_id_i = '0;
  logic [15:0] burst_length_i = '0;
  logic [7:0]  priority_level_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [7:0]  ran_id_o;
  logic        finished_o;
  logic [31:0] completion_time_o;
  logic [31:0] turnaround_o;
  logic [31:0] waiting_o;

  preemptive_priority_scheduler_top dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .opcode_i,
    .task_id_i,
    .burst_length_i,
    .priority_level_i,
    .out_valid_o,
    .out_ready_i,
    .status_o,
    .ran_id_o,
    .finished_o,
    .completion_time_o,
    .turnaround_o,
    .waiting_o
  );

  // Task beats waiting to be driven, and the results owed by the block,
  // oldest first.
  cmd_t pending_beats[$];
  out_t due_results[$];
  cmd_t on_wire;

  int unsigned n_items;
  int unsigned beats_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  int unsigned big_left = 3;
  logic        hold_off = 1'b0;

  // Scheduler shadow: clock, slot occupancy and per-slot task record.
  logic [31:0] clock_now = '0;
  logic        slot_busy [SLOTS] = '{default: 1'b0};
  logic [7:0]  slot_tid  [SLOTS];
  logic [31:0] slot_stamp[SLOTS];
  logic [15:0] slot_len  [SLOTS];
  logic [15:0] slot_left [SLOTS];
  logic [7:0]  slot_prio [SLOTS];

  // Apply one task beat to the shadow and return the result beat it owes.
  function automatic out_t schedule_step(cmd_t b);
    out_t        r;
    int          pick;
    int          s;
    logic [15:0] need;
    r = '0;
    pick = -1;
    if (b.op == OP_ARRIVE) begin
      // A zero burst counts as one tick of service.
      need = (b.burst == 16'd0) ? 16'd1 : b.burst;
      for (s = 0; s < SLOTS; s++)
        if (!slot_busy[s] && pick < 0) pick = s;
      if (pick < 0) begin
        r.status = ST_FULL;
      end else begin
        slot_busy[pick]  = 1'b1;
        slot_tid[pick]   = b.id;
        slot_stamp[pick] = clock_now;
        slot_len[pick]   = need;
        slot_left[pick]  = need;
        slot_prio[pick]  = b.prio;
        r.status = ST_ACCEPT;
      end
      return r;
    end
    // Smallest priority number wins, then the earlier stamp, then the lower slot.
    for (s = 0; s < SLOTS; s++) begin
      if (slot_busy[s] && (pick < 0 || slot_prio[s] < slot_prio[pick] ||
          (slot_prio[s] == slot_prio[pick] && slot_stamp[s] < slot_stamp[pick])))
        pick = s;
    end
    clock_now = clock_now + 32'd1;
    if (pick < 0) begin
      r.status = ST_IDLE;
      return r;
    end
    r.status = ST_RAN;
    r.ran_id = slot_tid[pick];
    if (slot_left[pick] != 16'd0) slot_left[pick] = slot_left[pick] - 16'd1;
    if (slot_left[pick] == 16'd0) begin
      slot_busy[pick]   = 1'b0;
      r.finished        = 1'b1;
      r.completion_time = clock_now;
      r.turnaround      = clock_now - slot_stamp[pick];
      r.waiting         = r.turnaround - {16'd0, slot_len[pick]};
    end
    return r;
  endfunction

  task automatic queue_beat(op_e op, logic [7:0] id, logic [15:0] len, logic [7:0] prio);
    cmd_t b;
    b.op = op;
    b.id = id;
    b.burst = len;
    b.prio = prio;
    pending_beats.push_back(b);
  endtask

  // Mostly short bursts so tasks finish often; a few huge ones, kept at the
  // back of the priority order so they cannot starve the table for good.
  task automatic queue_random_arrival();
    int unsigned roll;
    logic [15:0] len;
    logic [7:0]  prio;
    roll = $urandom_range(0, 99);
    if (roll < 2) len = 16'd0;
    else if (roll < 88) len = 16'($urandom_range(1, 4));
    else if (roll < 99 || big_left == 0) len = 16'($urandom_range(5, 20));
    else begin
      len = 16'($urandom_range(1000, 65535));
      big_left--;
    end
    if (len >= 16'd1000) prio = 8'($urandom_range(240, 255));
    else if ($urandom_range(0, 9) < 6) prio = 8'($urandom_range(0, 3));
    else prio = 8'($urandom);
    queue_beat(OP_ARRIVE, 8'($urandom), len, prio);
  endtask

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(12 * 800000);
    $display("FAIL");
    $finish;
  end

  // Input driver: present the next beat once the previous one is taken, hold
  // valid and payload steady while the block stalls, and idle in short bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      opcode_i <= 1'b0;
      task_id_i <= '0;
      burst_length_i <= '0;
      priority_level_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        due_results.push_back(schedule_step(on_wire));
        beats_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_beats.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (pending_beats.size() > CALM_BEATS && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 4);
          in_valid_i <= 1'b0;
        end else begin
          on_wire = pending_beats.pop_front();
          in_valid_i <= 1'b1;
          opcode_i <= on_wire.op;
          task_id_i <= on_wire.id;
          burst_length_i <= on_wire.burst;
          priority_level_i <= on_wire.prio;
        end
      end
    end
  end

  // Output monitor: check each result beat against the oldest owed result,
  // then decide whether to stall the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (due_results.size() == 0) begin
          $error("result beat with no task beat outstanding");
          mismatches++;
        end else begin
          out_t want;
          want = due_results.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_o);
            mismatches++;
          end
          if (ran_id_o !== want.ran_id) begin
            $error("ran_id: expected %0d, actual %0d", want.ran_id, ran_id_o);
            mismatches++;
          end
          if (finished_o !== want.finished) begin
            $error("finished: expected %0d, actual %0d", want.finished, finished_o);
            mismatches++;
          end
          if (completion_time_o !== want.completion_time) begin
            $error("completion_time: expected %0d, actual %0d",
                   want.completion_time, completion_time_o);
            mismatches++;
          end
          if (turnaround_o !== want.turnaround) begin
            $error("turnaround: expected %0d, actual %0d", want.turnaround, turnaround_o);
            mismatches++;
          end
          if (waiting_o !== want.waiting) begin
            $error("waiting: expected %0d, actual %0d", want.waiting, waiting_o);
            mismatches++;
          end
        end
      end
      if (hold_off) begin
        out_ready_i <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else if (results_seen + CALM_BEATS < n_items && $urandom_range(0, 4) == 0) begin
        recv_stall = $urandom_range(0, 4);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Back-pressure episode: refuse results for a long stretch while the driver
  // keeps offering beats, so the command queue fills and input ready drops.
  initial begin
    @(posedge rst_ni);
    while (beats_sent < 400) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    int unsigned i;
    int unsigned run_len;
    int unsigned arrive_pct;

    // Directed part.
    // Tick on an empty table: idle, time still moves; payload must be ignored.
    queue_beat(OP_TICK, 8'hFF, 16'hFFFF, 8'hFF);
    // Zero burst is served as a one-tick task.
    queue_beat(OP_ARRIVE, 8'h00, 16'h0000, 8'h00);
    queue_beat(OP_TICK, 8'h00, 16'h0000, 8'h00);
    // Longest burst at the lowest priority: parks in a slot for the whole run.
    queue_beat(OP_ARRIVE, 8'hFF, 16'hFFFF, 8'hFF);
    // Fill every remaining slot at one time stamp, so ties fall back to slot order.
    for (i = 1; i < SLOTS; i++)
      queue_beat(OP_ARRIVE, 8'(8'h10 + i), 16'(i % 4 + 1), 8'(i % 3));
    // Table full: reject without touching state.
    queue_beat(OP_ARRIVE, 8'h5A, 16'h1234, 8'h00);
    for (i = 0; i < 4; i++)
      queue_beat(OP_TICK, 8'($urandom), 16'($urandom), 8'($urandom));

    // Random part in runs: arrival-heavy runs push the table to full, mixed
    // runs keep tasks preempting each other, and pure tick runs drain it down
    // to the long parked task.
    while (pending_beats.size() < RANDOM_BEATS + 24) begin
      case ($urandom_range(0, 2))
        0: arrive_pct = 75;
        1: arrive_pct = 30;
        default: arrive_pct = 0;
      endcase
      run_len = (arrive_pct == 0) ? $urandom_range(20, 80) : $urandom_range(8, 40);
      for (i = 0; i < run_len; i++) begin
        if ($urandom_range(0, 99) < arrive_pct) queue_random_arrival();
        else queue_beat(OP_TICK, 8'($urandom), 16'($urandom), 8'($urandom));
      end
    end
    n_items = pending_beats.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: every beat driven and taken, every owed result seen.
    do
      @(posedge clk_i);
    while (pending_beats.size() != 0 || in_valid_i || due_results.size() != 0);
    // Leave room for any stray result beat to show up.
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// File: sim.f
rtl/pps_pkg.sv
rtl/pps_ram.sv
rtl/pps_front.sv
rtl/pps_back.sv
rtl/preemptive_priority_scheduler_top.sv
rtl/pps_checker.sv
test/tb_preemptive_priority_scheduler_top.sv
